[hdl/mhpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

	// heap geometry
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int FILL_W   = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 24;
	localparam int TAG_W    = 16;
	localparam int CNT_W    = 8;
	localparam int OP_W     = 2;
	localparam int STAT_W   = 2;

	// stream widths
	localparam int IN_BITS  = OP_W + KEY_W + TAG_W + CNT_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = KEY_W + TAG_W + CNT_W + FILL_W + 1 + STAT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// operation codes, code 3 behaves as peek
	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} stat_t;

	// one heap entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic up_rd;
		logic up_cmp;
		logic dn_load;
		logic dn_rd;
		logic dn_cmp;
		logic load_out;
	} ctl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic push_ok;
		logic pop_ok;
		logic at_root;
		logic up_swap;
		logic dn_leaf;
		logic dn_swap;
	} dp_stat_t;

endpackage

`default_nettype wire

[hdl/max_heap_priority_queue.sv]
// flow: a peek or refused op goes from input transfer straight to the result register,
// a push sifts up from its new slot and a pop sifts down from the root, one heap level
// per read state and compare-and-write state on the entry memory
// input: no new item is taken until the result of the last one is loaded, so the
// sift loop and any stall on the output side hold the input
// reset: arst_n clears the fill count and control; the entry memory holds no reset
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue import mhpq_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	// op[1:0], key[25:2], tag[41:26], item_count[49:42], zero fill
	input  wire  [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  wire               m_tready,
	// top_key[23:0], top_tag[39:24], top_count[47:40], fill_level[54:48],
	// is_empty[55], status[57:56], zero fill
	output logic [OUT_W-1:0]  m_tdata
);

	ctl_cmd_t             cmd;
	dp_stat_t             stat;
	entry_t               in_entry;
	entry_t               out_top;
	logic [FILL_W-1:0]    out_fill;
	logic                 out_empty;
	logic [STAT_W-1:0]    out_status;

	// input unpacking
	assign in_entry.key = s_tdata[OP_W +: KEY_W];
	assign in_entry.tag = s_tdata[OP_W + KEY_W +: TAG_W];
	assign in_entry.cnt = s_tdata[OP_W + KEY_W + TAG_W +: CNT_W];

	// output packing
	assign m_tdata = OUT_W'({out_status, out_empty, out_fill,
		out_top.cnt, out_top.tag, out_top.key});

	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.cmd       (cmd),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	mhpq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (s_tdata[OP_W-1:0]),
		.in_entry   (in_entry),
		.out_top    (out_top),
		.out_fill   (out_fill),
		.out_empty  (out_empty),
		.out_status (out_status)
	);

endmodule

`default_nettype wire

[hdl/mhpq_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module mhpq_dp import mhpq_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              stat,
	input  wire  [OP_W-1:0]       in_op,
	input  entry_t                in_entry,
	output entry_t                out_top,
	output logic [FILL_W-1:0]     out_fill,
	output logic                  out_empty,
	output logic [STAT_W-1:0]     out_status
);

	// entry memory, two registered read ports, one write port
	entry_t mem [CAPACITY];

	entry_t              rda_q, rdb_q;
	entry_t              mv_q;
	entry_t              root_q;
	logic [IDX_W-1:0]    at_q;
	logic [FILL_W-1:0]   fill_q;
	logic [STAT_W-1:0]   status_q;

	logic                rd_en_a, rd_en_b, wr_en;
	logic [IDX_W-1:0]    rd_addr_a, rd_addr_b, wr_addr;
	entry_t              wr_data;

	logic [IDX_W-1:0]    parent;
	logic [IDX_W+1:0]    left, right, fill_ext;
	logic                right_ok, pick_right;
	entry_t              pick;
	logic [IDX_W-1:0]    pick_idx;
	logic [FILL_W-1:0]   fill_dec;

	// index arithmetic and key compares
	always_comb begin
		parent     = (at_q - IDX_W'(1)) >> 1;
		left       = {1'b0, at_q, 1'b1};
		right      = left + (IDX_W+2)'(1);
		fill_ext   = (IDX_W+2)'(fill_q);
		fill_dec   = fill_q - FILL_W'(1);
		right_ok   = right < fill_ext;
		pick_right = right_ok && (rda_q.key < rdb_q.key);
		pick       = pick_right ? rdb_q : rda_q;
		pick_idx   = pick_right ? right[IDX_W-1:0] : left[IDX_W-1:0];
	end

	// status toward the controller
	always_comb begin
		stat.push_ok = (in_op == OP_PUSH) && (fill_q < FILL_W'(CAPACITY));
		stat.pop_ok  = (in_op == OP_POP) && (fill_q != '0);
		stat.at_root = (at_q == '0);
		stat.up_swap = mv_q.key > rda_q.key;
		stat.dn_leaf = left >= fill_ext;
		stat.dn_swap = mv_q.key < pick.key;
	end

	// memory port selection
	always_comb begin
		rd_en_a   = 1'b0;
		rd_en_b   = 1'b0;
		rd_addr_a = left[IDX_W-1:0];
		rd_addr_b = right[IDX_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = at_q;
		wr_data   = mv_q;
		if (cmd.accept && stat.pop_ok) begin
			rd_en_a   = 1'b1;
			rd_addr_a = fill_dec[IDX_W-1:0];
		end
		if (cmd.up_rd) begin
			if (stat.at_root) begin
				wr_en = 1'b1;
			end else begin
				rd_en_a   = 1'b1;
				rd_addr_a = parent;
			end
		end
		if (cmd.up_cmp) begin
			wr_en = 1'b1;
			if (stat.up_swap) begin
				wr_data = rda_q;
			end
		end
		if (cmd.dn_rd) begin
			if (stat.dn_leaf) begin
				wr_en = 1'b1;
			end else begin
				rd_en_a = 1'b1;
				rd_en_b = 1'b1;
			end
		end
		if (cmd.dn_cmp) begin
			wr_en = 1'b1;
			if (stat.dn_swap) begin
				wr_data = pick;
			end
		end
	end

	// memory array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en_a) begin
			rda_q <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rdb_q <= mem[rd_addr_b];
		end
	end

	// copy of the root slot, follows every write to index zero
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == '0)) begin
			root_q <= wr_data;
		end
	end

	// moving entry
	always_ff @(posedge clk) begin
		if (cmd.accept && stat.push_ok) begin
			mv_q <= in_entry;
		end else if (cmd.dn_load) begin
			mv_q <= rda_q;
		end
	end

	// fill count, current index and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			at_q     <= '0;
			status_q <= STAT_OK;
		end else begin
			if (cmd.accept) begin
				status_q <= STAT_OK;
				if (in_op == OP_PUSH && !stat.push_ok) begin
					status_q <= STAT_FULL;
				end
				if (in_op == OP_POP && !stat.pop_ok) begin
					status_q <= STAT_EMPTY;
				end
				if (stat.push_ok) begin
					at_q   <= fill_q[IDX_W-1:0];
					fill_q <= fill_q + FILL_W'(1);
				end
				if (stat.pop_ok) begin
					at_q   <= '0;
					fill_q <= fill_dec;
				end
			end
			if (cmd.up_cmp && stat.up_swap) begin
				at_q <= parent;
			end
			if (cmd.dn_cmp && stat.dn_swap) begin
				at_q <= pick_idx;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_top    <= (fill_q == '0) ? entry_t'('0) : root_q;
			out_fill   <= fill_q;
			out_empty  <= (fill_q == '0);
			out_status <= status_q;
		end
	end

endmodule

`default_nettype wire

[hdl/mhpq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ctrl import mhpq_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	input  wire      in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  wire      out_ready
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (stat.push_ok) begin
						state_nxt = S_UP_RD;
					end else if (stat.pop_ok) begin
						state_nxt = S_DN_LOAD;
					end else begin
						state_nxt = S_DONE;
					end
				end
			end
			S_UP_RD: begin
				state_nxt = stat.at_root ? S_DONE : S_UP_CMP;
			end
			S_UP_CMP: begin
				state_nxt = stat.up_swap ? S_UP_RD : S_DONE;
			end
			S_DN_LOAD: begin
				state_nxt = S_DN_RD;
			end
			S_DN_RD: begin
				state_nxt = stat.dn_leaf ? S_DONE : S_DN_CMP;
			end
			S_DN_CMP: begin
				state_nxt = stat.dn_swap ? S_DN_RD : S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_UP_RD:   cmd.up_rd    = 1'b1;
			S_UP_CMP:  cmd.up_cmp   = 1'b1;
			S_DN_LOAD: cmd.dn_load  = 1'b1;
			S_DN_RD:   cmd.dn_rd    = 1'b1;
			S_DN_CMP:  cmd.dn_cmp   = 1'b1;
			S_DONE:    cmd.load_out = out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/mhpq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module mhpq_checker import mhpq_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              s_tvalid,
	input wire              s_tready,
	input wire [IN_W-1:0]   s_tdata,
	input wire              m_tvalid,
	input wire              m_tready,
	input wire [OUT_W-1:0]  m_tdata
);

	localparam int FILL_LO = KEY_W + TAG_W + CNT_W;
	localparam int EMPTY_B = FILL_LO + FILL_W;
	localparam int STAT_LO = EMPTY_B + 1;

	logic [FILL_W-1:0] fill;
	logic [STAT_W-1:0] status;
	logic              empty;

	assign fill   = m_tdata[FILL_LO +: FILL_W];
	assign empty  = m_tdata[EMPTY_B];
	assign status = m_tdata[STAT_LO +: STAT_W];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// empty flag matches fill level, empty heap shows a zero top entry
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (empty == (fill == '0)) &&
		(!empty || m_tdata[FILL_LO-1:0] == '0))
		else $error("empty flag or top entry inconsistent");

	// fill level never beyond capacity
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> fill <= FILL_W'(CAPACITY))
		else $error("fill level beyond capacity");

	// refused push only when full, refused pop only when empty
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status != STAT_FULL || fill == FILL_W'(CAPACITY)) &&
		(status != STAT_EMPTY || fill == '0))
		else $error("refusal status with wrong fill level");

	// no input taken while the previous input is still in work
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

`default_nettype wire

[dv/max_heap_priority_queue_tb.sv]
`timescale 1ns / 1ps

module max_heap_priority_queue_tb;
	import mhpq_pkg::*;

	// unused op code, the block treats it as peek
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// result field offsets in m_tdata
	localparam int TAG_LSB  = KEY_W;
	localparam int CNT_LSB  = TAG_LSB + TAG_W;
	localparam int FILL_LSB = CNT_LSB + CNT_W;
	localparam int EMPT_LSB = FILL_LSB + FILL_W;
	localparam int STAT_LSB = EMPT_LSB + 1;

	localparam int REPORT_LIMIT = 10;

	// one heap request as it travels on the input stream
	typedef struct packed {
		logic [OP_W-1:0] op;
		entry_t          ent;
	} heap_req_t;

	// top of heap report as it travels on the output stream
	typedef struct packed {
		entry_t            top;
		logic [FILL_W-1:0] fill;
		logic              empty;
		stat_t             status;
	} top_report_t;

	// shadow heap that predicts the top report of every request
	class heap_scoreboard;
		entry_t      slots [CAPACITY];
		int unsigned held;
		top_report_t pending_tops [$];
		int unsigned mismatch_count;

		function new();
			held = 0;
			mismatch_count = 0;
		endfunction

		function void swap_slots(int unsigned a, int unsigned b);
			entry_t t;
			t = slots[a];
			slots[a] = slots[b];
			slots[b] = t;
		endfunction

		// move a new entry up while strictly greater than its parent
		function void sift_up(int unsigned at);
			int unsigned parent;
			while (at > 0) begin
				parent = (at - 1) / 2;
				if (slots[at].key <= slots[parent].key)
					break;
				swap_slots(at, parent);
				at = parent;
			end
		endfunction

		// move the root down, right child only when strictly larger
		function void sift_down();
			int unsigned at, left, pick;
			at = 0;
			while (1) begin
				left = at * 2 + 1;
				if (left >= held)
					break;
				pick = left;
				if (left + 1 < held && slots[left].key < slots[left + 1].key)
					pick = left + 1;
				if (!(slots[at].key < slots[pick].key))
					break;
				swap_slots(at, pick);
				at = pick;
			end
		endfunction

		// apply one accepted request and queue the expected report
		function void apply_request(heap_req_t req);
			top_report_t r;
			r.status = STAT_OK;
			if (req.op == OP_PUSH) begin
				if (held >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					slots[held] = req.ent;
					held++;
					sift_up(held - 1);
				end
			end else if (req.op == OP_POP) begin
				if (held == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					held--;
					slots[0] = slots[held];
					sift_down();
				end
			end
			r.top   = (held > 0) ? slots[0] : '0;
			r.fill  = held[FILL_W-1:0];
			r.empty = (held == 0);
			pending_tops.push_back(r);
		endfunction

		function void report(string what, top_report_t exp, top_report_t act);
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t %s: exp key=%h tag=%h cnt=%h fill=%0d empty=%b st=%0d",
					$realtime, what, exp.top.key, exp.top.tag, exp.top.cnt, exp.fill,
					exp.empty, exp.status);
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t %s: act key=%h tag=%h cnt=%h fill=%0d empty=%b st=%0d",
					$realtime, what, act.top.key, act.top.tag, act.top.cnt, act.fill,
					act.empty, act.status);
		endfunction

		// compare one output transfer with the oldest expectation
		function void check_top(logic [OUT_W-1:0] d);
			top_report_t act, exp;
			act.top.key = d[KEY_W-1:0];
			act.top.tag = d[TAG_LSB +: TAG_W];
			act.top.cnt = d[CNT_LSB +: CNT_W];
			act.fill    = d[FILL_LSB +: FILL_W];
			act.empty   = d[EMPT_LSB];
			act.status  = stat_t'(d[STAT_LSB +: STAT_W]);
			if (pending_tops.size() == 0) begin
				exp = '0;
				report("unexpected transfer", exp, act);
			end else begin
				exp = pending_tops.pop_front();
				if (act.top.key !== exp.top.key || act.top.tag !== exp.top.tag ||
						act.top.cnt !== exp.top.cnt || act.fill !== exp.fill ||
						act.empty !== exp.empty || act.status !== exp.status)
					report("wrong top report", exp, act);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;

	heap_scoreboard sb = new();

	// idle spans per side, and a one-shot long hold-off of the output side
	int src_gap_max  = 14;
	int sink_gap_max = 14;
	int sink_hold    = 0;

	max_heap_priority_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// offer one request after a random gap, return once it is accepted
	task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			logic [TAG_W-1:0] tag, logic [CNT_W-1:0] cnt);
		heap_req_t req;
		int gap;
		req.op      = op;
		req.ent.key = key;
		req.ent.tag = tag;
		req.ent.cnt = cnt;
		gap = (src_gap_max > 0) ? $urandom_range(0, src_gap_max) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = IN_W'({cnt, tag, key, op});
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.apply_request(req);
	endtask

	// key mix that makes equal keys and near-maximum keys common
	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(0, 3);
		if (sel == 0)
			return KEY_W'($urandom_range(0, 7));
		else if (sel == 1)
			return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 3));
		else
			return KEY_W'($urandom);
	endfunction

	task automatic send_random(logic [OP_W-1:0] op);
		send_request(op, pick_key(), TAG_W'($urandom), CNT_W'($urandom));
	endtask

	// sender pause until every expected report has come back
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending_tops.size() != 0)
			@(posedge clk);
	endtask

	// mixed random segment, percentages of push and pop
	task automatic run_segment(int n, int push_pct, int pop_pct);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < push_pct)
				send_random(OP_PUSH);
			else if (r < push_pct + pop_pct)
				send_random(OP_POP);
			else if (r < 98)
				send_random(OP_PEEK);
			else
				send_random(OP_UNUSED);
		end
	endtask

	// output side: random stalls, one long hold-off on request
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready = 1'b0;
				repeat (sink_hold) @(negedge clk);
				sink_hold = 0;
			end
			gap = (sink_gap_max > 0) ? $urandom_range(0, sink_gap_max) : 0;
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_top(m_tdata);
		end
	end

	// run limit
	initial begin
		#5000000;
		$display("max_heap_priority_queue: mismatch");
		$finish;
	end

	// main sequence
	initial begin
		s_tvalid = 1'b0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty heap cases, field extremes, equal keys
		send_request(OP_PEEK, '0, '0, '0);
		send_request(OP_POP, '1, '1, '1);
		send_request(OP_UNUSED, '1, '1, '1);
		send_request(OP_PUSH, '0, '0, '0);
		send_request(OP_PUSH, '1, '1, '1);
		send_request(OP_PUSH, 24'h800000, 16'h5555, 8'haa);
		send_request(OP_PUSH, 24'h800000, 16'haaaa, 8'h55);
		send_request(OP_PEEK, '1, '1, '1);
		send_request(OP_UNUSED, '0, '0, '0);
		send_request(OP_POP, '0, '0, '0);
		send_request(OP_PUSH, 24'h123456, 16'h0001, 8'h01);
		send_request(OP_PUSH, 24'h123456, 16'h0002, 8'h02);
		send_request(OP_PUSH, 24'h000100, 16'h0003, 8'h03);
		send_request(OP_POP, '0, '0, '0);
		send_request(OP_POP, '0, '0, '0);
		send_request(OP_POP, '0, '0, '0);
		send_request(OP_POP, '0, '0, '0);
		send_request(OP_POP, '0, '0, '0);
		send_request(OP_POP, '0, '0, '0);
		send_request(OP_PEEK, '0, '0, '0);
		wait_drained();

		// fill past capacity, then drain past empty
		for (int i = 0; i < CAPACITY + 4; i++)
			send_random(OP_PUSH);
		send_random(OP_PEEK);
		for (int i = 0; i < CAPACITY + 4; i++)
			send_random(OP_POP);
		wait_drained();

		// random segments with changing op mix and idling
		for (int seg = 0; seg < 8; seg++) begin
			src_gap_max  = seg[0] ? 14 : 0;
			sink_gap_max = seg[1] ? 14 : 0;
			if (seg == 2)
				sink_hold = 600;
			case (seg % 3)
				0: run_segment(230, 65, 25);
				1: run_segment(230, 25, 65);
				default: run_segment(230, 45, 45);
			endcase
			wait_drained();
		end

		// let any stray result show up before the verdict
		repeat (40) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending_tops.size() == 0)
			$display("max_heap_priority_queue: match");
		else
			$display("max_heap_priority_queue: mismatch");
		$finish;
	end

endmodule
